@@ design/wtdf_pkg.sv @@
`default_nettype none

package wtdf_pkg;

  // Sizes
  localparam int WTDF_PATH_DEPTH   = 64;
  localparam int WTDF_CORDIC_ITERS = 16;
  localparam int WTDF_ADDR_W       = 4;
  localparam int DW                = 38;  // CORDIC x/y datapath
  localparam int ZW                = 35;  // angle, radians Q2.30 with headroom

  // Angles and gain
  localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic [23:0]          INV_GAIN    = 24'd10188012;

  // Register reset values
  localparam logic [14:0] TURN_RATE_RST = 15'd205;
  localparam logic [14:0] LIN_RATE_RST  = 15'd6144;
  localparam logic [14:0] ANG_THR_RST   = 15'd201;
  localparam logic [15:0] ARR_TOL_RST   = 16'd655;

  typedef enum logic [1:0] {
    REG_TURN_RATE = 2'd0,
    REG_LIN_RATE  = 2'd1,
    REG_ANG_THR   = 2'd2,
    REG_ARR_TOL   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [14:0] turn_speed;
    logic [14:0] fwd_speed;
    logic [14:0] angle_thr;
    logic [15:0] arrive_tol;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] angular_cmd;
    logic signed [15:0] linear_cmd;
    logic               all_reached;
    logic               last_of_run;
  } res_t;

  typedef struct packed {
    logic start;
    logic rot;
  } cord_ctl_t;

  // Floor-truncated arctangent of 2^-i, radians Q2.30.
  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    unique case (i)
      5'd0:  v = 35'sd843314856;
      5'd1:  v = 35'sd497837829;
      5'd2:  v = 35'sd263043836;
      5'd3:  v = 35'sd133525158;
      5'd4:  v = 35'sd67021686;
      5'd5:  v = 35'sd33543515;
      5'd6:  v = 35'sd16775850;
      5'd7:  v = 35'sd8388437;
      5'd8:  v = 35'sd4194282;
      5'd9:  v = 35'sd2097149;
      5'd10: v = 35'sd1048575;
      5'd11: v = 35'sd524287;
      5'd12: v = 35'sd262143;
      5'd13: v = 35'sd131071;
      5'd14: v = 35'sd65535;
      5'd15: v = 35'sd32767;
      5'd16: v = 35'sd16383;
      5'd17: v = 35'sd8191;
      5'd18: v = 35'sd4095;
      5'd19: v = 35'sd2047;
      5'd20: v = 35'sd1023;
      5'd21: v = 35'sd511;
      5'd22: v = 35'sd255;
      5'd23: v = 35'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ design/wtdf_if.sv @@
`default_nettype none

interface wtdf_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic               path_start;

  modport source (output valid, req_type, pos_x, pos_y, quat_w, quat_x, quat_y, quat_z,
                  path_start, input ready);
  modport sink (input valid, req_type, pos_x, pos_y, quat_w, quat_x, quat_y, quat_z,
                path_start, output ready);
endinterface

interface wtdf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angular_cmd;
  logic signed [15:0] linear_cmd;
  logic               all_reached;
  logic               last_of_run;

  modport source (output valid, angular_cmd, linear_cmd, all_reached, last_of_run,
                  input ready);
  modport sink (input valid, angular_cmd, linear_cmd, all_reached, last_of_run,
                output ready);
endinterface

`default_nettype wire

@@ design/waypoint_turn_then_drive_follower_core.sv @@
// Channel   Dir  Handshake        Carries
// in_chan   in   valid/ready      req_type, pos_x, pos_y, quat_w..quat_z, path_start
// out_chan  out  valid/ready      angular_cmd, linear_cmd, all_reached, last_of_run
// APB       in   psel/penable     four configuration registers at 4*i, pready tied high
//
// A waypoint load leaves the input ready. A pose transaction holds the input off until the
// sequencer is done with it: the shared CORDIC unit runs up to three passes (yaw, rotation,
// bearing) and the skip loop reads the path RAM one entry at a time, with a compare state
// after each read. The input is not ready until the last result has been loaded into the
// output stage.
// Reset is synchronous and active low; the path RAM is not cleared.
// A stalled output holds its transaction; the second result waits in the sequencer.
`default_nettype none

module waypoint_turn_then_drive_follower_core
  import wtdf_pkg::*;
#(
  parameter int PATH_DEPTH        = WTDF_PATH_DEPTH,
  parameter int CORDIC_ITERATIONS = WTDF_CORDIC_ITERS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  wtdf_in_if.sink                     in_chan,
  wtdf_out_if.source                  out_chan,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [WTDF_ADDR_W-1:0] paddr,
  input  wire logic [31:0]            pwdata,
  output logic      [31:0]            prdata,
  output logic                        pready
);

  localparam int CW = $clog2(PATH_DEPTH + 1);
  localparam int AW = $clog2(PATH_DEPTH);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_CHK   = 14'b00000000000010,
    S_SKIP  = 14'b00000000000100,
    S_SKCMP = 14'b00000000001000,
    S_QUAT  = 14'b00000000010000,
    S_QCHK  = 14'b00000000100000,
    S_YAW   = 14'b00000001000000,
    S_ROT   = 14'b00000010000000,
    S_GAIN  = 14'b00000100000000,
    S_BEAR  = 14'b00001000000000,
    S_BWAIT = 14'b00010000000000,
    S_DEC   = 14'b00100000000000,
    S_EMIT1 = 14'b01000000000000,
    S_EMIT2 = 14'b10000000000000
  } state_t;

  function automatic logic signed [DW-1:0] gain_fix(input logic signed [48:0] ph,
                                                    input logic signed [48:0] pl);
    logic signed [64:0] full;
    full = (65'(ph) <<< 16) + 65'(pl);
    return full[24 +: DW];
  endfunction

  cfg_t cfg;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt, tidx_r, tidx_nxt, ld_base;
  logic          fin_r, fin_nxt, ld_room, in_acc, slot_free;
  logic signed [31:0] px_r, px_nxt, py_r, py_nxt, wx, wy;
  logic signed [15:0] qw_r, qw_nxt, qx_r, qx_nxt, qy_r, qy_nxt, qz_r, qz_nxt;
  logic signed [32:0] dx_r, dx_nxt, dy_r, dy_nxt, sk_dx, sk_dy;
  logic [32:0]        sk_abs;
  logic               sk_hit;
  logic [3:0]         qk_r, qk_nxt;
  logic [2:0]         pk_r, pk_nxt, gk_r, gk_nxt;
  logic               pv_r, pv_nxt;
  logic signed [23:0] mul_a, qa, qb;
  logic signed [24:0] mul_b;
  logic signed [48:0] p_r, p_nxt, lo_r, lo_nxt;
  logic signed [33:0] acc_d_r, acc_d_nxt, acc_vx_r, acc_vx_nxt;
  logic signed [33:0] acc_m_r, acc_m_nxt, acc_vy_r, acc_vy_nxt, pq;
  logic signed [34:0] m2, vy2;
  logic [34:0]        m2_abs;
  logic signed [DW-1:0] rx_r, rx_nxt, ry_r, ry_nxt, rx_abs;
  logic signed [DW-1:0] cx_in, cy_in, cx, cy;
  logic signed [ZW-1:0] cz_in, cz, bear_r, bear_nxt, bear_abs;
  logic                 cord_done;
  cord_ctl_t            cord_ctl;
  logic signed [15:0]   tr_pos, lr_pos;
  res_t res_a_r, res_a_nxt, res_b_r, res_b_nxt, out_r, out_nxt;
  logic two_r, two_nxt, out_valid_r, out_valid_nxt;
  logic ram_we;
  logic [AW-1:0] ram_waddr;
  logic [63:0]   ram_rdata;

  wtdf_regs u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  wtdf_ram #(.WIDTH(64), .DEPTH(PATH_DEPTH)) u_path (
    .clk,
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({in_chan.pos_x, in_chan.pos_y}),
    .raddr (tidx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  wtdf_cordic #(.ITERS(CORDIC_ITERATIONS)) u_cordic (
    .clk, .rst_n,
    .ctl   (cord_ctl),
    .x_in  (cx_in),
    .y_in  (cy_in),
    .z_in  (cz_in),
    .x_out (cx),
    .y_out (cy),
    .z_out (cz),
    .done  (cord_done)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign slot_free     = !out_valid_r || out_chan.ready;

  assign out_chan.valid       = out_valid_r;
  assign out_chan.angular_cmd = out_r.angular_cmd;
  assign out_chan.linear_cmd  = out_r.linear_cmd;
  assign out_chan.all_reached = out_r.all_reached;
  assign out_chan.last_of_run = out_r.last_of_run;

  assign ld_base = in_chan.path_start ? '0 : count_r;
  assign ld_room = ld_base < CW'(PATH_DEPTH);

  assign wx     = $signed(ram_rdata[63:32]);
  assign wy     = $signed(ram_rdata[31:0]);
  assign sk_dx  = 33'(wx) - 33'(px_r);
  assign sk_dy  = 33'(wy) - 33'(py_r);
  assign sk_abs = sk_dx[32] ? 33'(-sk_dx) : 33'(sk_dx);
  assign sk_hit = sk_abs <= 33'(cfg.arrive_tol);

  assign pq     = p_r[33:0];
  assign m2     = $signed({acc_m_r, 1'b0});
  assign m2_abs = m2[34] ? 35'(-m2) : 35'(m2);
  assign vy2    = $signed({acc_vy_r, 1'b0});

  assign rx_abs   = rx_r[DW-1] ? -rx_r : rx_r;
  assign bear_abs = bear_r[ZW-1] ? -bear_r : bear_r;
  assign tr_pos   = $signed({1'b0, cfg.turn_speed});
  assign lr_pos   = $signed({1'b0, cfg.fwd_speed});

  // Quaternion product schedule: four squares, then xz, wy, xy, wz.
  always_comb begin
    unique case (qk_r[2:0])
      3'd0: begin qa = 24'(qw_r); qb = 24'(qw_r); end
      3'd1: begin qa = 24'(qx_r); qb = 24'(qx_r); end
      3'd2: begin qa = 24'(qy_r); qb = 24'(qy_r); end
      3'd3: begin qa = 24'(qz_r); qb = 24'(qz_r); end
      3'd4: begin qa = 24'(qx_r); qb = 24'(qz_r); end
      3'd5: begin qa = 24'(qw_r); qb = 24'(qy_r); end
      3'd6: begin qa = 24'(qx_r); qb = 24'(qy_r); end
      3'd7: begin qa = 24'(qw_r); qb = 24'(qz_r); end
    endcase
  end

  assign p_nxt = mul_a * mul_b;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    tidx_nxt   = tidx_r;
    fin_nxt    = fin_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    qw_nxt     = qw_r;
    qx_nxt     = qx_r;
    qy_nxt     = qy_r;
    qz_nxt     = qz_r;
    dx_nxt     = dx_r;
    dy_nxt     = dy_r;
    qk_nxt     = qk_r;
    pk_nxt     = pk_r;
    pv_nxt     = 1'b0;
    gk_nxt     = gk_r;
    lo_nxt     = lo_r;
    acc_d_nxt  = acc_d_r;
    acc_vx_nxt = acc_vx_r;
    acc_m_nxt  = acc_m_r;
    acc_vy_nxt = acc_vy_r;
    rx_nxt     = rx_r;
    ry_nxt     = ry_r;
    bear_nxt   = bear_r;
    res_a_nxt  = res_a_r;
    res_b_nxt  = res_b_r;
    two_nxt    = two_r;
    out_nxt    = out_r;
    out_valid_nxt = out_chan.ready ? 1'b0 : out_valid_r;
    mul_a      = '0;
    mul_b      = '0;
    ram_we     = 1'b0;
    ram_waddr  = ld_base[AW-1:0];
    cord_ctl   = '0;
    cx_in      = DW'(dx_r);
    cy_in      = DW'(dy_r);
    cz_in      = '0;

    if (pv_r) begin
      unique case (pk_r)
        3'd0, 3'd1: begin acc_d_nxt = acc_d_r + pq; acc_vx_nxt = acc_vx_r + pq; end
        3'd2, 3'd3: begin acc_d_nxt = acc_d_r + pq; acc_vx_nxt = acc_vx_r - pq; end
        3'd4:       acc_m_nxt  = acc_m_r + pq;
        3'd5:       acc_m_nxt  = acc_m_r - pq;
        3'd6, 3'd7: acc_vy_nxt = acc_vy_r + pq;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_chan.req_type) begin
            count_nxt = ld_base;
            if (in_chan.path_start) begin
              tidx_nxt = '0;
              fin_nxt  = 1'b0;
            end
            if (ld_room) begin
              ram_we    = 1'b1;
              count_nxt = ld_base + 1'b1;
            end
          end else begin
            px_nxt    = in_chan.pos_x;
            py_nxt    = in_chan.pos_y;
            qw_nxt    = in_chan.quat_w;
            qx_nxt    = in_chan.quat_x;
            qy_nxt    = in_chan.quat_y;
            qz_nxt    = in_chan.quat_z;
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        state_nxt = ((count_r == '0) || fin_r) ? S_IDLE : S_SKIP;
      end
      S_SKIP: begin
        if (tidx_r >= count_r) begin
          fin_nxt   = 1'b1;
          res_a_nxt = '{angular_cmd: '0, linear_cmd: '0, all_reached: 1'b1,
                        last_of_run: 1'b1};
          two_nxt   = 1'b0;
          state_nxt = S_EMIT1;
        end else begin
          state_nxt = S_SKCMP;
        end
      end
      S_SKCMP: begin
        if (sk_hit) begin
          tidx_nxt  = tidx_r + 1'b1;
          state_nxt = S_SKIP;
        end else begin
          dx_nxt     = sk_dx;
          dy_nxt     = sk_dy;
          qk_nxt     = '0;
          acc_d_nxt  = '0;
          acc_vx_nxt = '0;
          acc_m_nxt  = '0;
          acc_vy_nxt = '0;
          state_nxt  = S_QUAT;
        end
      end
      S_QUAT: begin
        if (qk_r[3]) begin
          state_nxt = S_QCHK;
        end else begin
          mul_a  = qa;
          mul_b  = 25'(qb);
          pv_nxt = 1'b1;
          pk_nxt = qk_r[2:0];
          qk_nxt = qk_r + 1'b1;
        end
      end
      S_QCHK: begin
        // Pitch at a right angle, or an all-zero quaternion, gives a yaw of zero.
        if (m2_abs >= 35'($unsigned(acc_d_r))) begin
          cord_ctl  = '{start: 1'b1, rot: 1'b1};
          state_nxt = S_ROT;
        end else begin
          cord_ctl  = '{start: 1'b1, rot: 1'b0};
          cx_in     = DW'(acc_vx_r);
          cy_in     = DW'(vy2);
          state_nxt = S_YAW;
        end
      end
      S_YAW: begin
        if (cord_done) begin
          cord_ctl  = '{start: 1'b1, rot: 1'b1};
          cz_in     = -cz;
          state_nxt = S_ROT;
        end
      end
      S_ROT: begin
        if (cord_done) begin
          gk_nxt    = '0;
          state_nxt = S_GAIN;
        end
      end
      S_GAIN: begin
        // Each coordinate is scaled by the gain inverse in two parts, its low 16 bits and its upper 22 bits.
        mul_b  = $signed({1'b0, INV_GAIN});
        gk_nxt = gk_r + 1'b1;
        unique case (gk_r)
          3'd0: mul_a = $signed({8'b0, cx[15:0]});
          3'd1: begin
            lo_nxt = p_r;
            mul_a  = 24'($signed(cx[DW-1:16]));
          end
          3'd2: begin
            rx_nxt = gain_fix(p_r, lo_r);
            mul_a  = $signed({8'b0, cy[15:0]});
          end
          3'd3: begin
            lo_nxt = p_r;
            mul_a  = 24'($signed(cy[DW-1:16]));
          end
          default: begin
            ry_nxt    = gain_fix(p_r, lo_r);
            state_nxt = S_BEAR;
          end
        endcase
      end
      S_BEAR: begin
        if (rx_r == '0) begin
          priority if (ry_r > 0) begin
            bear_nxt = HALF_PI_Q30;
          end else if (ry_r < 0) begin
            bear_nxt = -HALF_PI_Q30;
          end else begin
            bear_nxt = '0;
          end
          state_nxt = S_DEC;
        end else begin
          cord_ctl  = '{start: 1'b1, rot: 1'b0};
          cx_in     = rx_abs;
          cy_in     = rx_r[DW-1] ? -ry_r : ry_r;
          state_nxt = S_BWAIT;
        end
      end
      S_BWAIT: begin
        if (cord_done) begin
          bear_nxt  = cz;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_EMIT1;
        if (bear_abs > ZW'({cfg.angle_thr, 16'b0})) begin
          res_a_nxt = '{angular_cmd: (!bear_r[ZW-1] && (bear_r != '0)) ? tr_pos : -tr_pos,
                        linear_cmd: '0, all_reached: 1'b0, last_of_run: 1'b1};
          two_nxt   = 1'b0;
        end else begin
          res_a_nxt = '{angular_cmd: '0, linear_cmd: '0, all_reached: 1'b0,
                        last_of_run: 1'b0};
          res_b_nxt = '{angular_cmd: '0, linear_cmd: '0, all_reached: 1'b0,
                        last_of_run: 1'b1};
          if (rx_abs > DW'(cfg.arrive_tol)) begin
            res_b_nxt.linear_cmd = rx_r[DW-1] ? -lr_pos : lr_pos;
          end
          two_nxt   = 1'b1;
        end
      end
      S_EMIT1: begin
        if (slot_free) begin
          out_nxt       = res_a_r;
          out_valid_nxt = 1'b1;
          state_nxt     = two_r ? S_EMIT2 : S_IDLE;
        end
      end
      S_EMIT2: begin
        if (slot_free) begin
          out_nxt       = res_b_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      tidx_r      <= '0;
      fin_r       <= 1'b0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      tidx_r      <= tidx_nxt;
      fin_r       <= fin_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    px_r     <= px_nxt;
    py_r     <= py_nxt;
    qw_r     <= qw_nxt;
    qx_r     <= qx_nxt;
    qy_r     <= qy_nxt;
    qz_r     <= qz_nxt;
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    qk_r     <= qk_nxt;
    pk_r     <= pk_nxt;
    gk_r     <= gk_nxt;
    p_r      <= p_nxt;
    lo_r     <= lo_nxt;
    acc_d_r  <= acc_d_nxt;
    acc_vx_r <= acc_vx_nxt;
    acc_m_r  <= acc_m_nxt;
    acc_vy_r <= acc_vy_nxt;
    rx_r     <= rx_nxt;
    ry_r     <= ry_nxt;
    bear_r   <= bear_nxt;
    res_a_r  <= res_a_nxt;
    res_b_r  <= res_b_nxt;
    two_r    <= two_nxt;
    out_r    <= out_nxt;
  end

endmodule

`default_nettype wire

@@ design/wtdf_ram.sv @@
`default_nettype none

module wtdf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/wtdf_regs.sv @@
`default_nettype none

module wtdf_regs
  import wtdf_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [WTDF_ADDR_W-1:0] paddr,
  input  wire logic [31:0]            pwdata,
  output logic      [31:0]            prdata,
  output logic                        pready,
  output cfg_t                        cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.turn_speed <= TURN_RATE_RST;
      cfg_r.fwd_speed  <= LIN_RATE_RST;
      cfg_r.angle_thr  <= ANG_THR_RST;
      cfg_r.arrive_tol <= ARR_TOL_RST;
    end else if (wr) begin
      unique case (idx)
        REG_TURN_RATE: cfg_r.turn_speed <= pwdata[14:0];
        REG_LIN_RATE:  cfg_r.fwd_speed  <= pwdata[14:0];
        REG_ANG_THR:   cfg_r.angle_thr  <= pwdata[14:0];
        REG_ARR_TOL:   cfg_r.arrive_tol <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TURN_RATE: prdata = 32'(cfg_r.turn_speed);
      REG_LIN_RATE:  prdata = 32'(cfg_r.fwd_speed);
      REG_ANG_THR:   prdata = 32'(cfg_r.angle_thr);
      REG_ARR_TOL:   prdata = 32'(cfg_r.arrive_tol);
    endcase
  end

endmodule

`default_nettype wire

@@ design/wtdf_cordic.sv @@
`default_nettype none

module wtdf_cordic
  import wtdf_pkg::*;
#(
  parameter int ITERS = WTDF_CORDIC_ITERS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cord_ctl_t            ctl,
  input  wire logic signed [DW-1:0] x_in,
  input  wire logic signed [DW-1:0] y_in,
  input  wire logic signed [ZW-1:0] z_in,
  output logic signed [DW-1:0]      x_out,
  output logic signed [DW-1:0]      y_out,
  output logic signed [ZW-1:0]      z_out,
  output logic                      done
);

  localparam int IW = (ITERS > 1) ? $clog2(ITERS) : 1;

  logic signed [DW-1:0] x_r, x_nxt, y_r, y_nxt, xs, ys;
  logic signed [ZW-1:0] z_r, z_nxt, at;
  logic [IW-1:0]        it_r, it_nxt;
  logic                 busy_r, busy_nxt, done_r, done_nxt;
  logic                 rot_r, rot_nxt, zero_r, zero_nxt, plus;

  assign xs = x_r >>> it_r;
  assign ys = y_r >>> it_r;
  assign at = atan_q30(5'(it_r));
  // plus: x - y*2^-i, y + x*2^-i, angle reduced by the table entry.
  assign plus = rot_r ? !z_r[ZW-1] : !(y_r > 0);

  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = zero_r ? '0 : z_r;
  assign done  = done_r;

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    it_nxt   = it_r;
    busy_nxt = busy_r;
    rot_nxt  = rot_r;
    zero_nxt = zero_r;
    done_nxt = 1'b0;
    priority if (busy_r) begin
      x_nxt  = plus ? x_r - ys : x_r + ys;
      y_nxt  = plus ? y_r + xs : y_r - xs;
      z_nxt  = plus ? z_r - at : z_r + at;
      it_nxt = it_r + 1'b1;
      if (it_r == IW'(ITERS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (ctl.start) begin
      rot_nxt  = ctl.rot;
      it_nxt   = '0;
      busy_nxt = 1'b1;
      x_nxt    = x_in;
      y_nxt    = y_in;
      if (ctl.rot) begin
        zero_nxt = 1'b0;
        z_nxt    = z_in;
        priority if (z_in > HALF_PI_Q30) begin
          x_nxt = -x_in;
          y_nxt = -y_in;
          z_nxt = z_in - PI_Q30;
        end else if (z_in < -HALF_PI_Q30) begin
          x_nxt = -x_in;
          y_nxt = -y_in;
          z_nxt = z_in + PI_Q30;
        end
      end else begin
        zero_nxt = (x_in == '0) && (y_in == '0);
        z_nxt    = '0;
        if (x_in[DW-1]) begin
          // Left half plane: fold over by a half turn first.
          z_nxt = y_in[DW-1] ? -PI_Q30 : PI_Q30;
          x_nxt = -x_in;
          y_nxt = -y_in;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    it_r   <= it_nxt;
    rot_r  <= rot_nxt;
    zero_r <= zero_nxt;
  end

endmodule

`default_nettype wire

@@ design/wtdf_checker.sv @@
`default_nettype none

module wtdf_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               in_req_type,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [15:0] out_angular_cmd,
  input wire logic signed [15:0] out_linear_cmd,
  input wire logic               out_all_reached,
  input wire logic               out_last_of_run
);

  // A held result must stay offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A pose transaction always occupies the sequencer for at least the next cycle.
  a_pose_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_req_type |=> !in_ready)
    else $error("input ready straight after a pose transaction");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_all_reached |->
      out_last_of_run && (out_angular_cmd == 16'sd0) && (out_linear_cmd == 16'sd0))
    else $error("path-finished result is not a lone zero command");

  // Forward motion only ever comes as the closing result, never with a turn.
  a_drive_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_linear_cmd != 16'sd0) |->
      out_last_of_run && (out_angular_cmd == 16'sd0))
    else $error("forward command combined with a turn or not last");

endmodule

bind waypoint_turn_then_drive_follower_core wtdf_checker u_wtdf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .in_req_type     (in_chan.req_type),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_angular_cmd (out_chan.angular_cmd),
  .out_linear_cmd  (out_chan.linear_cmd),
  .out_all_reached (out_chan.all_reached),
  .out_last_of_run (out_chan.last_of_run)
);

`default_nettype wire

@@ sim/wtdf_follower_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wtdf_follower_checker
  import wtdf_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  wtdf_in_if                          in_mon,
  wtdf_out_if                         out_mon,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [WTDF_ADDR_W-1:0] paddr,
  input  wire logic [31:0]            pwdata,
  input  wire logic                   pready,
  output int                          errors,
  output int                          pending,
  output int                          n_results,
  output int                          n_turns,
  output int                          n_drives,
  output int                          n_finishes
);

  localparam longint ARCTAN_Q30 [24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686,
    33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
    524287, 262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127
  };
  localparam int     STEPS   = (WTDF_CORDIC_ITERS < 24) ? WTDF_CORDIC_ITERS : 24;
  localparam longint PI_L    = longint'(PI_Q30);
  localparam longint HALF_PI = longint'(HALF_PI_Q30);
  localparam longint GAIN_L  = longint'({1'b0, INV_GAIN});

  logic [14:0] turn_mag, drive_mag, bearing_limit;
  logic [15:0] reach_tol;
  longint      route_x [WTDF_PATH_DEPTH];
  longint      route_y [WTDF_PATH_DEPTH];
  int          route_len, target;
  bit          route_done;
  res_t        cmd_q [$];

  function automatic longint absval(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic queue_cmd(input res_t r);
    cmd_q.insert(cmd_q.size(), r);
  endtask

  // Vectoring CORDIC: angle of (x, y) in Q2.30.
  function automatic longint heading_of(input longint y, input longint x);
    longint z, nx;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_L : -PI_L;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += ARCTAN_Q30[i];
      end else begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= ARCTAN_Q30[i];
      end
      x = nx;
    end
    return z;
  endfunction

  task automatic turn_frame(inout longint x, inout longint y, input longint a);
    longint nx;
    if (a > HALF_PI) begin
      x = -x; y = -y; a -= PI_L;
    end else if (a < -HALF_PI) begin
      x = -x; y = -y; a += PI_L;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (a >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        a -= ARCTAN_Q30[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        a += ARCTAN_Q30[i];
      end
      x = nx;
    end
    x = (x * GAIN_L) >>> 24;
    y = (y * GAIN_L) >>> 24;
  endtask

  function automatic longint yaw_of(input longint w, input longint x, input longint y,
                                    input longint z);
    longint norm, tilt;
    norm = w * w + x * x + y * y + z * z;
    tilt = 2 * (x * z - w * y);
    if (absval(tilt) >= norm) return 0;
    return heading_of(2 * (x * y + w * z), w * w + x * x - y * y - z * z);
  endfunction

  function automatic res_t command(input longint ang, input longint lin, input bit all,
                                   input bit last);
    res_t r;
    r.angular_cmd = 16'(ang);
    r.linear_cmd  = 16'(lin);
    r.all_reached = all;
    r.last_of_run = last;
    return r;
  endfunction

  task automatic plan_commands();
    longint px, py, dx, dy, yaw, bearing, tol;
    px  = longint'(in_mon.pos_x);
    py  = longint'(in_mon.pos_y);
    tol = longint'({1'b0, reach_tol});
    if (in_mon.req_type) begin
      if (in_mon.path_start) begin
        route_len = 0; target = 0; route_done = 1'b0;
      end
      if (route_len < WTDF_PATH_DEPTH) begin
        route_x[route_len] = px;
        route_y[route_len] = py;
        route_len++;
      end
      return;
    end
    if (route_len == 0 || route_done) return;
    while (target < route_len && absval(route_x[target] - px) <= tol) target++;
    if (target >= route_len) begin
      route_done = 1'b1;
      queue_cmd(command(0, 0, 1'b1, 1'b1));
      return;
    end
    yaw = yaw_of(longint'(in_mon.quat_w), longint'(in_mon.quat_x),
                 longint'(in_mon.quat_y), longint'(in_mon.quat_z));
    dx = route_x[target] - px;
    dy = route_y[target] - py;
    turn_frame(dx, dy, -yaw);
    // A target straight abeam gives a quarter turn by the side it lies on.
    if (dx == 0) bearing = (dy > 0) ? HALF_PI : ((dy < 0) ? -HALF_PI : 0);
    else bearing = heading_of((dx < 0) ? -dy : dy, absval(dx));
    if (absval(bearing) > (longint'(bearing_limit) << 16)) begin
      queue_cmd(command((bearing > 0) ? longint'(turn_mag) : -longint'(turn_mag),
                        0, 1'b0, 1'b1));
      return;
    end
    queue_cmd(command(0, 0, 1'b0, 1'b0));
    if (absval(dx) > tol)
      queue_cmd(command(0, (dx > 0) ? longint'(drive_mag) : -longint'(drive_mag),
                        1'b0, 1'b1));
    else
      queue_cmd(command(0, 0, 1'b0, 1'b1));
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      turn_mag = TURN_RATE_RST;
      drive_mag = LIN_RATE_RST;
      bearing_limit = ANG_THR_RST;
      reach_tol = ARR_TOL_RST;
      route_len = 0; target = 0; route_done = 1'b0;
      cmd_q.delete();
      errors = 0; n_results = 0; n_turns = 0; n_drives = 0; n_finishes = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_TURN_RATE: turn_mag = pwdata[14:0];
          REG_LIN_RATE:  drive_mag = pwdata[14:0];
          REG_ANG_THR:   bearing_limit = pwdata[14:0];
          REG_ARR_TOL:   reach_tol = pwdata[15:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        n_results++;
        if (cmd_q.size() == 0) begin
          $error("result transaction with nothing expected");
          errors++;
        end else begin
          want = cmd_q.pop_front();
          if (want.angular_cmd != 0) n_turns++;
          if (want.linear_cmd != 0) n_drives++;
          if (want.all_reached) n_finishes++;
          if (out_mon.angular_cmd !== want.angular_cmd) begin
            $error("angular_cmd: expected %0d, got %0d", want.angular_cmd,
                   out_mon.angular_cmd);
            errors++;
          end
          if (out_mon.linear_cmd !== want.linear_cmd) begin
            $error("linear_cmd: expected %0d, got %0d", want.linear_cmd,
                   out_mon.linear_cmd);
            errors++;
          end
          if (out_mon.all_reached !== want.all_reached) begin
            $error("all_reached: expected %0d, got %0d", want.all_reached,
                   out_mon.all_reached);
            errors++;
          end
          if (out_mon.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                   out_mon.last_of_run);
            errors++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) plan_commands();
    end
    pending = cmd_q.size();
  end

endmodule

`default_nettype wire

@@ sim/tb_waypoint_turn_then_drive_follower_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tb_waypoint_turn_then_drive_follower_core;
  import wtdf_pkg::*;

  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 195;
  localparam int IDLE_LIMIT  = 6000;

  logic                   clk;
  logic                   rst_n;
  logic                   psel, penable, pwrite;
  logic [WTDF_ADDR_W-1:0] paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;

  int errors, pending, n_results, n_turns, n_drives, n_finishes;
  int items_sent, idle_cycles;
  bit calm, squeeze;

  logic [15:0] cur_tol;
  longint      route_x [$];
  longint      route_y [$];
  int          aim;
  bit          route_done;

  wtdf_in_if  in_if ();
  wtdf_out_if out_if ();

  waypoint_turn_then_drive_follower_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  wtdf_follower_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .errors     (errors),
    .pending    (pending),
    .n_results  (n_results),
    .n_turns    (n_turns),
    .n_drives   (n_drives),
    .n_finishes (n_finishes)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [15:0] quat_part();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  // Receiver: random stalls, plus one long hold-off while the sender keeps offering.
  initial begin
    int stall;
    bit squeezed;
    stall = 0;
    squeezed = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze && !squeezed) begin
        squeezed = 1'b1;
        stall = 500;
      end
      if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else begin
        stall = gap_len();
        out_if.ready <= (stall == 0);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** waypoint_turn_then_drive_follower_core: FAILED **");
      $finish;
    end
  end

  task automatic offer(input bit rt, input longint x, input longint y,
                       input logic signed [15:0] w, input logic signed [15:0] qx,
                       input logic signed [15:0] qy, input logic signed [15:0] qz,
                       input bit ps);
    int gap;
    in_if.valid      <= 1'b1;
    in_if.req_type   <= rt;
    in_if.pos_x      <= 32'(x);
    in_if.pos_y      <= 32'(y);
    in_if.quat_w     <= w;
    in_if.quat_x     <= qx;
    in_if.quat_y     <= qy;
    in_if.quat_z     <= qz;
    in_if.path_start <= ps;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
    // Track the route so that poses can be aimed at the current waypoint.
    if (rt) begin
      if (ps) begin
        route_x.delete(); route_y.delete(); aim = 0; route_done = 1'b0;
      end
      if (route_x.size() < WTDF_PATH_DEPTH) begin
        route_x.insert(route_x.size(), longint'($signed(32'(x))));
        route_y.insert(route_y.size(), longint'($signed(32'(y))));
      end
    end else if (route_x.size() > 0 && !route_done) begin
      while (aim < route_x.size() &&
             (route_x[aim] - longint'($signed(32'(x)))) <= longint'(cur_tol) &&
             (longint'($signed(32'(x))) - route_x[aim]) <= longint'(cur_tol))
        aim++;
      if (aim >= route_x.size()) route_done = 1'b1;
    end
    gap = gap_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic pose(input longint x, input longint y, input logic signed [15:0] w,
                      input logic signed [15:0] z);
    offer(1'b0, x, y, w, 16'sd0, 16'sd0, z, 1'b0);
  endtask

  task automatic waypoint(input longint x, input longint y, input bit ps);
    offer(1'b1, x, y, quat_part(), quat_part(), quat_part(), quat_part(), ps);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    // A pose with no result may still be in flight.
    repeat (300) @(posedge clk);
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (idx == REG_ARR_TOL) cur_tol = value[15:0];
  endtask

  task automatic random_route();
    int len, poses;
    longint x, y, off;
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
    x = longint'($urandom_range(0, 400000)) - 200000;
    for (int k = 0; k < len; k++) begin
      if (k > 0 && $urandom_range(0, 3) != 0)
        x += ($urandom_range(0, 1) ? 1 : -1) * longint'($urandom_range(1000, 300000));
      y = longint'($urandom_range(0, 600000)) - 300000;
      waypoint(x, y, k == 0);
    end
    poses = 2 * len + $urandom_range(0, 4);
    for (int k = 0; k < poses && !route_done; k++) begin
      if ($urandom_range(0, 99) < 45)
        off = (cur_tol == 0) ? 0 : longint'($urandom_range(0, cur_tol));
      else
        off = longint'($urandom_range(0, 300000));
      if ($urandom_range(0, 1)) off = -off;
      if ($urandom_range(0, 19) == 0)
        offer(1'b0, x, y, quat_part(), quat_part(), quat_part(), quat_part(), 1'b0);
      else
        offer(1'b0, route_x[aim] + off,
              route_y[aim] + longint'($urandom_range(0, 400000)) - 200000,
              quat_part(), quat_part(), quat_part(), quat_part(), 1'b0);
    end
  endtask

  initial begin
    logic [31:0] setting [4];
    rst_n   <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    in_if.valid      <= 1'b0;
    in_if.req_type   <= 1'b0;
    in_if.pos_x      <= '0;
    in_if.pos_y      <= '0;
    in_if.quat_w     <= '0;
    in_if.quat_x     <= '0;
    in_if.quat_y     <= '0;
    in_if.quat_z     <= '0;
    in_if.path_start <= 1'b0;
    items_sent  = 0;
    idle_cycles = 0;
    calm        = 1'b0;
    squeeze     = 1'b0;
    cur_tol     = ARR_TOL_RST;
    aim         = 0;
    route_done  = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty path, field extremes, degenerate attitudes.
    pose(1000, 2000, 16'sd16384, 16'sd0);
    waypoint(32'sh7FFFFFFF, -64'sd2147483648, 1'b1);
    pose(-64'sd2147483648, 32'sh7FFFFFFF, 16'sd0, 16'sd0);
    offer(1'b0, 0, 0, 16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 1'b0);
    offer(1'b0, -5, 7, -16'sd16384, -16'sd16384, 16'sd16384, 16'sd16384, 1'b0);
    // Drive ahead, drive astern, turn right, then skip two and finish.
    waypoint(100000, 0, 1'b1);
    waypoint(100000, 50000, 1'b0);
    waypoint(300000, 0, 1'b0);
    pose(0, 0, 16'sd16384, 16'sd0);
    pose(0, 0, 16'sd0, 16'sd16384);
    pose(0, 200000, 16'sd16384, 16'sd0);
    pose(100300, 0, 16'sd16384, 16'sd0);
    pose(300000, 0, 16'sd16384, 16'sd0);
    pose(0, 0, 16'sd16384, 16'sd0);
    waypoint(500000, 0, 1'b0);
    pose(0, 0, 16'sd16384, 16'sd0);
    // Target nearly abeam at a quarter-turn yaw.
    waypoint(1000, 0, 1'b1);
    pose(0, 0, 16'sd11585, 16'sd11585);
    pose(0, 0, 16'sd11585, -16'sd11585);
    // Overfill the store; the excess is dropped.
    for (int k = 0; k < WTDF_PATH_DEPTH + 5; k++) waypoint(k * 7000 + 5000, k * 300, k == 0);
    pose(-100000, 0, 16'sd16384, 16'sd0);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: setting = '{32'(TURN_RATE_RST), 32'(LIN_RATE_RST), 32'(ANG_THR_RST),
                       32'(ARR_TOL_RST)};
        1: setting = '{32'd32767, 32'd32767, 32'd25736, 32'd65535};
        2: setting = '{32'd0, 32'd0, 32'd0, 32'd0};
        default: setting = '{$urandom, $urandom, 32'($urandom_range(0, 25736)),
                             32'($urandom_range(0, 4000))};
      endcase
      reg_write(REG_TURN_RATE, setting[0]);
      reg_write(REG_LIN_RATE, setting[1]);
      reg_write(REG_ANG_THR, setting[2]);
      reg_write(REG_ARR_TOL, setting[3]);
      calm = (ph == 4);
      if (ph == 3) squeeze = 1'b1;
      for (int start = items_sent; items_sent - start < PHASE_ITEMS; ) begin
        if ($urandom_range(0, 9) == 0)
          offer($urandom_range(0, 1), longint'($signed($urandom)),
                longint'($signed($urandom)), quat_part(), quat_part(), quat_part(),
                quat_part(), $urandom_range(0, 1));
        else
          random_route();
      end
      settle();
    end

    $display("Sent %0d input transactions over %0d register settings.", items_sent,
             PHASES + 1);
    $display("Checked %0d results: %0d turns, %0d drives, %0d completed paths.",
             n_results, n_turns, n_drives, n_finishes);
    if (errors == 0)
      $display("** waypoint_turn_then_drive_follower_core: PASSED **");
    else
      $display("** waypoint_turn_then_drive_follower_core: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
